FILE: rtl/jet_pkg.sv
// Shared constants, register indexes and control structs for the Julia escape-time block.
`timescale 1ns / 1ps

package jet_pkg;

	localparam int FRAC_BITS      = 26;
	localparam int COORD_BITS_DEF = 12;
	localparam int ITER_BITS_DEF  = 16;
	localparam int CFG_IDX_BITS   = 3;
	localparam int CFG_DATA_BITS  = 32;

	// register indexes on the config port
	localparam logic [CFG_IDX_BITS-1:0] CFG_C_RE     = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_C_IM     = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_START_RE = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_START_IM = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_STEP     = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ITER = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] CFG_RADIUS   = 3'd6;

	// reset values
	localparam logic [30:0] STEP_RST     = 31'd67108;
	localparam logic [15:0] MAX_ITER_RST = 16'd100;
	localparam logic [30:0] RADIUS_RST   = 31'd268435456;

	typedef struct packed {
		logic signed [31:0] c_re;
		logic signed [31:0] c_im;
		logic signed [31:0] start_re;
		logic signed [31:0] start_im;
		logic [30:0]        step;
		logic [15:0]        max_iter;
		logic [30:0]        radius_sq;
	} cfg_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;  // latch pixel coordinates, clear iteration index
		logic scale;   // coord * step
		logic load;    // z0 = start + scaled coord
		logic mul;     // a*a, b*b, a*b
		logic sq;      // shift and saturate products
		logic upd;     // next z, advance index
		logic ld_out;  // move result into the output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic esc;   // |z|^2 above radius
		logic last;  // this index is the final one allowed
	} sts_t;

endpackage

FILE: rtl/julia_escape_time.sv
// Top level of the Julia escape-time block: config registers, controller and datapath.
`timescale 1ns / 1ps

// Julia escape-time engine. Each input item (pixel_x, pixel_y) maps to
// z0 = (start_re + pixel_x*step) + i*(start_im + pixel_y*step) in signed Q5.26,
// then z <- z*z + c runs until |z|^2 exceeds escape_radius_sq or max_iter
// points have been checked (max_iter of 0 acts as 1). One result item per
// input item: the echoed coordinates, the escape index (index 0 reads as 1)
// and escaped; escaped = 0 with iteration_count = 0 means the limit was hit.
// Squares and sums saturate to 32 bits, products are floored.
// One item at a time: each of the n points checked (1..max_iter) goes through
// the loop of multiply, shift/saturate and compare/update states in the
// datapath, then the result is loaded once the output register is free or
// being taken. The next item can then be accepted while that result still
// sits in the output register.
// Config writes (cfg_we, cfg_idx, cfg_wdata) take effect at once and must be
// issued only while no item is in flight; indexes 0..6 are c_re, c_im,
// start_re, start_im, step, max_iter, escape_radius_sq, others are ignored.

module julia_escape_time #(
	parameter int COORD_BITS = jet_pkg::COORD_BITS_DEF,
	parameter int ITER_BITS  = jet_pkg::ITER_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// config write port
	input  logic                              cfg_we,
	input  logic [jet_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
	input  logic [jet_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
	// input item
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [COORD_BITS-1:0]             pixel_x,
	input  logic [COORD_BITS-1:0]             pixel_y,
	// result item
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [COORD_BITS-1:0]             out_x,
	output logic [COORD_BITS-1:0]             out_y,
	output logic [ITER_BITS-1:0]              iteration_count,
	output logic                              escaped
);
	import jet_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	jet_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// sequencer: owns in_ready and the output valid flag
	jet_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// arithmetic and the output payload register
	jet_dp #(
		.COORD_BITS (COORD_BITS),
		.ITER_BITS  (ITER_BITS)
	) u_dp (
		.clk             (clk),
		.cfg             (cfg),
		.cmd             (cmd),
		.sts             (sts),
		.pixel_x         (pixel_x),
		.pixel_y         (pixel_y),
		.out_x           (out_x),
		.out_y           (out_y),
		.iteration_count (iteration_count),
		.escaped         (escaped)
	);

endmodule

FILE: rtl/jet_regs.sv
// Configuration register file of the Julia escape-time block.
`timescale 1ns / 1ps

module jet_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [jet_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
	input  logic [jet_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
	output jet_pkg::cfg_t                     cfg
);
	import jet_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.c_re      <= '0;
			cfg_q.c_im      <= '0;
			cfg_q.start_re  <= '0;
			cfg_q.start_im  <= '0;
			cfg_q.step      <= STEP_RST;
			cfg_q.max_iter  <= MAX_ITER_RST;
			cfg_q.radius_sq <= RADIUS_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_C_RE:     cfg_q.c_re      <= $signed(cfg_wdata);
				CFG_C_IM:     cfg_q.c_im      <= $signed(cfg_wdata);
				CFG_START_RE: cfg_q.start_re  <= $signed(cfg_wdata);
				CFG_START_IM: cfg_q.start_im  <= $signed(cfg_wdata);
				CFG_STEP:     cfg_q.step      <= cfg_wdata[30:0];
				CFG_MAX_ITER: cfg_q.max_iter  <= cfg_wdata[15:0];
				CFG_RADIUS:   cfg_q.radius_sq <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/jet_ctrl.sv
// Sequencing state machine of the Julia escape-time block.
`timescale 1ns / 1ps

module jet_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  jet_pkg::sts_t sts,
	output jet_pkg::cmd_t cmd
);
	import jet_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SCALE = 7'b0000010,
		ST_LOAD  = 7'b0000100,
		ST_MUL   = 7'b0001000,
		ST_SQ    = 7'b0010000,
		ST_CHK   = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;
	logic   finish;

	assign slot_free = !out_valid_q || out_ready;
	assign finish    = sts.esc || sts.last;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_SCALE;
			ST_SCALE: state_d = ST_LOAD;
			ST_LOAD:  state_d = ST_MUL;
			ST_MUL:   state_d = ST_SQ;
			ST_SQ:    state_d = ST_CHK;
			ST_CHK:   state_d = finish ? ST_DONE : ST_MUL;
			ST_DONE:  if (slot_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.accept = (state_q == ST_IDLE) && in_valid;
		cmd.scale  = (state_q == ST_SCALE);
		cmd.load   = (state_q == ST_LOAD);
		cmd.mul    = (state_q == ST_MUL);
		cmd.sq     = (state_q == ST_SQ);
		cmd.upd    = (state_q == ST_CHK) && !finish;
		cmd.ld_out = (state_q == ST_DONE) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

FILE: rtl/jet_dp.sv
// Fixed-point datapath of the Julia escape-time block: start point, z*z + c, escape test.
`timescale 1ns / 1ps

module jet_dp #(
	parameter int COORD_BITS = jet_pkg::COORD_BITS_DEF,
	parameter int ITER_BITS  = jet_pkg::ITER_BITS_DEF
) (
	input  logic                  clk,
	input  jet_pkg::cfg_t         cfg,
	input  jet_pkg::cmd_t         cmd,
	output jet_pkg::sts_t         sts,
	input  logic [COORD_BITS-1:0] pixel_x,
	input  logic [COORD_BITS-1:0] pixel_y,
	output logic [COORD_BITS-1:0] out_x,
	output logic [COORD_BITS-1:0] out_y,
	output logic [ITER_BITS-1:0]  iteration_count,
	output logic                  escaped
);
	import jet_pkg::*;

	localparam int PW = COORD_BITS + 31;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sh0000_0000_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -64'sh0000_0000_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [63:0] sx64(input logic signed [31:0] v);
		return $signed({{32{v[31]}}, v});
	endfunction

	logic [COORD_BITS-1:0] px_q, py_q;
	logic [PW-1:0]         prodx_q, prody_q;
	logic signed [31:0]    a_q, b_q;
	logic signed [63:0]    aa_q, bb_q, ab_q;
	logic signed [31:0]    a2_q, b2_q, cross_q;
	logic [15:0]           i_q;
	logic [COORD_BITS-1:0] out_x_q, out_y_q;
	logic [ITER_BITS-1:0]  cnt_q;
	logic                  esc_q;

	logic signed [63:0] sum_x, sum_y, next_a, next_b;
	logic [32:0]        mag_sq;
	logic [15:0]        limit;
	logic [15:0]        idx;
	logic [ITER_BITS+15:0] idx_w;

	assign sum_x  = $signed({{(64-PW){1'b0}}, prodx_q}) + sx64(cfg.start_re);
	assign sum_y  = $signed({{(64-PW){1'b0}}, prody_q}) + sx64(cfg.start_im);
	assign next_a = sx64(a2_q) - sx64(b2_q) + sx64(cfg.c_re);
	assign next_b = sx64(cross_q) + sx64(cfg.c_im);

	// squares are never negative after the floor shift
	assign mag_sq = {1'b0, a2_q} + {1'b0, b2_q};
	assign limit  = (cfg.max_iter == '0) ? 16'd1 : cfg.max_iter;

	assign sts.esc  = mag_sq > {2'b00, cfg.radius_sq};
	assign sts.last = ({1'b0, i_q} + 17'd1) >= {1'b0, limit};

	assign idx   = (i_q == '0) ? 16'd1 : i_q;
	assign idx_w = {{ITER_BITS{1'b0}}, idx};

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			px_q <= pixel_x;
			py_q <= pixel_y;
			i_q  <= '0;
		end
		if (cmd.scale) begin
			prodx_q <= PW'(px_q) * PW'(cfg.step);
			prody_q <= PW'(py_q) * PW'(cfg.step);
		end
		if (cmd.load) begin
			a_q <= sat32(sum_x);
			b_q <= sat32(sum_y);
		end
		if (cmd.mul) begin
			aa_q <= a_q * a_q;
			bb_q <= b_q * b_q;
			ab_q <= a_q * b_q;
		end
		if (cmd.sq) begin
			// arithmetic shift is a floor; 2ab comes from one bit less of shift
			a2_q    <= sat32(aa_q >>> FRAC_BITS);
			b2_q    <= sat32(bb_q >>> FRAC_BITS);
			cross_q <= sat32(ab_q >>> (FRAC_BITS - 1));
		end
		if (cmd.upd) begin
			a_q <= sat32(next_a);
			b_q <= sat32(next_b);
			i_q <= i_q + 16'd1;
		end
		if (cmd.ld_out) begin
			out_x_q <= px_q;
			out_y_q <= py_q;
			esc_q   <= sts.esc;
			cnt_q   <= sts.esc ? idx_w[ITER_BITS-1:0] : '0;
		end
	end

	assign out_x           = out_x_q;
	assign out_y           = out_y_q;
	assign iteration_count = cnt_q;
	assign escaped         = esc_q;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for julia_escape_time: directed corners, saturation and random views.
`timescale 1ns / 1ps

// Pixel items go in on a valid/ready channel and escape-time results come out on another.
// The predictor below recomputes every pixel's iteration in signed Q5.26 and checks each
// result in order.
// Register settings change only with the block drained.
// Random views use constants of the usual Julia family, so escape indexes spread over the
// whole iteration range.
// Full-range settings push the datapath into saturation.
// Two phases apply pressure: a long receiver hold-off, and a sender that pauses until all
// results are back.
module tb_top;
	import jet_pkg::*;

	localparam int     COORD_BITS = COORD_BITS_DEF;
	localparam int     ITER_BITS  = ITER_BITS_DEF;
	localparam int     Q_ONE      = 1 << FRAC_BITS;           // 1.0 in Q5.26
	localparam longint SAT_HI     = 64'sd2147483647;
	localparam longint SAT_LO     = -64'sd2147483648;
	localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 3'd7;  // no register behind it
	localparam longint LIMIT_NS   = 64'd40_000_000;          // watchdog limit
	localparam int     END_WAIT   = 200_000;                 // cycles to drain at the end

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [ITER_BITS-1:0]  count;
		logic                  esc;
	} pixel_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_idx;
	logic [CFG_DATA_BITS-1:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	logic [COORD_BITS-1:0] pixel_x;
	logic [COORD_BITS-1:0] pixel_y;
	logic out_valid;
	logic out_ready;
	logic [COORD_BITS-1:0] out_x;
	logic [COORD_BITS-1:0] out_y;
	logic [ITER_BITS-1:0]  iteration_count;
	logic                  escaped;

	cfg_t          model_cfg;         // mirror of the block's registers
	pixel_result_t expected_pixels[$];
	int            error_count    = 0;
	int            pixels_sent    = 0;
	int            settings_count = 0;
	int            escaped_seen   = 0;
	int            limit_seen     = 0;
	int            hold_cycles    = 0;  // receiver hold-off, counted down by the sink
	bit            no_idle        = 1'b0;

	julia_escape_time u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_idx         (cfg_idx),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.pixel_x         (pixel_x),
		.pixel_y         (pixel_y),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_x           (out_x),
		.out_y           (out_y),
		.iteration_count (iteration_count),
		.escaped         (escaped)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- prediction

	function automatic longint clamp32(input longint v);
		if (v > SAT_HI)
			return SAT_HI;
		if (v < SAT_LO)
			return SAT_LO;
		return v;
	endfunction

	// Escape-time iteration for one pixel under the mirrored registers.
	// Arithmetic shift on signed 64-bit products gives the floor the datapath uses.
	function automatic pixel_result_t escape_time(input logic [COORD_BITS-1:0] px,
			input logic [COORD_BITS-1:0] py);
		longint re, im, re_sq, im_sq, cross_term;
		int unsigned limit;
		pixel_result_t r;
		re = clamp32(longint'($signed(model_cfg.start_re)) +
			longint'(px) * longint'(model_cfg.step));
		im = clamp32(longint'($signed(model_cfg.start_im)) +
			longint'(py) * longint'(model_cfg.step));
		// a limit of zero still checks z0
		limit = (model_cfg.max_iter == 0) ? 1 : model_cfg.max_iter;
		r.x = px;
		r.y = py;
		r.count = '0;
		r.esc = 1'b0;
		for (int unsigned i = 0; i < limit; i++) begin
			re_sq = clamp32((re * re) >>> FRAC_BITS);
			im_sq = clamp32((im * im) >>> FRAC_BITS);
			// |z|^2 kept exact, strict compare
			if (re_sq + im_sq > longint'(model_cfg.radius_sq)) begin
				r.esc = 1'b1;
				r.count = (i == 0) ? ITER_BITS'(1) : ITER_BITS'(i);  // index 0 reads as 1
				break;
			end
			cross_term = clamp32((re * im) >>> (FRAC_BITS - 1));  // 2ab, floored
			re = clamp32(re_sq - im_sq + longint'($signed(model_cfg.c_re)));
			im = clamp32(cross_term + longint'($signed(model_cfg.c_im)));
		end
		return r;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string what, input longint got, input longint want);
		error_count++;
		if (error_count <= 100)
			$display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	always @(posedge clk) begin : check_results
		pixel_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_pixels.size() == 0) begin
				report_mismatch("result item with nothing pending", out_x, -1);
			end else begin
				want = expected_pixels.pop_front();
				if (out_x !== want.x)
					report_mismatch($sformatf("out_x (%0d,%0d)", want.x, want.y),
						out_x, want.x);
				if (out_y !== want.y)
					report_mismatch($sformatf("out_y (%0d,%0d)", want.x, want.y),
						out_y, want.y);
				if (iteration_count !== want.count)
					report_mismatch($sformatf("iteration_count (%0d,%0d)", want.x, want.y),
						iteration_count, want.count);
				if (escaped !== want.esc)
					report_mismatch($sformatf("escaped (%0d,%0d)", want.x, want.y),
						escaped, want.esc);
				if (want.esc)
					escaped_seen++;
				else
					limit_seen++;
			end
		end
	end

	// Result sink: random stalls, a no-stall stretch, and hold-offs on request.
	initial begin : result_sink
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				hold_cycles--;
			end else begin
				out_ready <= no_idle || ($urandom_range(99) >= 12);
			end
		end
	end

	// ---------------------------------------------------------------- driving

	// Drive one register; the caller drops cfg_we after its last write.
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			CFG_C_RE:     model_cfg.c_re = data;
			CFG_C_IM:     model_cfg.c_im = data;
			CFG_START_RE: model_cfg.start_re = data;
			CFG_START_IM: model_cfg.start_im = data;
			CFG_STEP:     model_cfg.step = data[30:0];
			CFG_MAX_ITER: model_cfg.max_iter = data[15:0];
			CFG_RADIUS:   model_cfg.radius_sq = data[30:0];
			default: ;
		endcase
	endtask

	// All seven registers; unused upper data bits carry junk.
	task automatic apply_settings(input cfg_t s);
		logic [31:0] junk;
		junk = $urandom();
		write_reg(CFG_C_RE, s.c_re);
		write_reg(CFG_C_IM, s.c_im);
		write_reg(CFG_START_RE, s.start_re);
		write_reg(CFG_START_IM, s.start_im);
		write_reg(CFG_STEP, {junk[31], s.step});
		write_reg(CFG_MAX_ITER, {junk[15:0], s.max_iter});
		write_reg(CFG_RADIUS, {junk[0], s.radius_sq});
		@(negedge clk) cfg_we <= 1'b0;
		settings_count++;
	endtask

	// Offer one pixel and return at the edge that takes it. Valid stays high so a
	// following item can go out back to back.
	task automatic send_pixel(input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
		@(negedge clk);
		if (!no_idle) begin
			while ($urandom_range(99) < 12) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		end
		in_valid <= 1'b1;
		pixel_x <= x;
		pixel_y <= y;
		do @(posedge clk); while (!in_ready);
		expected_pixels.push_back(escape_time(x, y));
		pixels_sent++;
	endtask

	// Drop valid and let every pending result come back.
	task automatic wait_idle();
		@(negedge clk) in_valid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Mostly uniform pixels, some pulled toward the center where orbits run long.
	task automatic send_random_pixels(input int n);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(9) < 3)
				send_pixel(COORD_BITS'(1536 + $urandom_range(1023)),
					COORD_BITS'(1536 + $urandom_range(1023)));
			else
				send_pixel(COORD_BITS'($urandom()), COORD_BITS'($urandom()));
		end
	endtask

	// A view of the usual Julia family: c in [-1,0.5] x [-1,1], plane +-1 to +-4 around a center near 0.
	function automatic cfg_t julia_view(input int unsigned iter_hi);
		cfg_t s;
		int unsigned span;
		span = $urandom_range(Q_ONE / 2048, Q_ONE / 512);
		s.c_re = $urandom_range(0, 3 * Q_ONE / 2) - Q_ONE;
		s.c_im = $urandom_range(0, 2 * Q_ONE) - Q_ONE;
		s.start_re = $urandom_range(0, Q_ONE / 2) - Q_ONE / 4 - span * 2048;
		s.start_im = $urandom_range(0, Q_ONE / 2) - Q_ONE / 4 - span * 2048;
		s.step = 31'(span);
		s.max_iter = 16'($urandom_range(1, iter_hi));
		s.radius_sq = 31'($urandom_range(Q_ONE, 16 * Q_ONE));
		return s;
	endfunction

	// ---------------------------------------------------------------- tests

	// Power-up registers: c = 0, so |z0| < 1 stays bounded and |z0| > 2 escapes at once.
	task automatic test_reset_defaults();
		send_pixel(0, 0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd1000, 0);
		send_pixel(12'd1100, 0);
		send_pixel(0, 12'd2000);
		send_pixel(12'd700, 12'd800);
	endtask

	task automatic test_julia_corners();
		cfg_t s;
		wait_idle();
		s.c_re = -53687091;               // -0.8
		s.c_im = 10468982;                // 0.156
		s.start_re = -2 * Q_ONE;
		s.start_im = -2 * Q_ONE;
		s.step = 31'(Q_ONE / 1024);       // 4096 pixels cover 4.0
		s.max_iter = MAX_ITER_RST;
		s.radius_sq = RADIUS_RST;
		apply_settings(s);
		send_pixel(12'd2048, 12'd2048);
		send_pixel(0, 0);
		send_pixel(12'd4095, 0);
		send_pixel(12'd1024, 12'd3072);
		send_pixel(12'd2300, 12'd2100);
	endtask

	// Limit of zero acts as one; full 16-bit limit with an orbit that never leaves zero.
	task automatic test_iteration_limits();
		cfg_t s;
		s = model_cfg;
		for (int lim = 0; lim < 2; lim++) begin
			wait_idle();
			s.max_iter = 16'(lim);
			apply_settings(s);
			send_pixel(12'd2048, 12'd2048);
			send_pixel(0, 0);
		end
		wait_idle();
		s.c_re = 0;
		s.c_im = 0;
		s.start_re = 0;
		s.start_im = 0;
		s.max_iter = 16'hFFFF;
		apply_settings(s);
		send_pixel(0, 0);
		send_pixel(12'd4095, 12'd4095);
	endtask

	task automatic test_saturation();
		cfg_t s;
		wait_idle();
		// saturated square exactly at the largest radius: not an escape, orbit pinned
		s.c_re = 32'sh7FFF_FFFF;
		s.c_im = 0;
		s.start_re = 32'sh7FFF_FFFF;
		s.start_im = 0;
		s.step = '0;
		s.max_iter = 16'd8;
		s.radius_sq = 31'h7FFF_FFFF;
		apply_settings(s);
		send_pixel(12'd4095, 0);
		send_pixel(0, 12'd4095);
		// most negative c: the real sum clips and the squares saturate
		wait_idle();
		s.c_re = 32'sh8000_0000;
		s.c_im = 32'sh8000_0000;
		apply_settings(s);
		send_pixel(12'd123, 12'd456);
		// start coordinates clip, radius zero
		wait_idle();
		s.c_re = 0;
		s.c_im = 0;
		s.start_re = 32'sh8000_0000;
		s.start_im = 32'sh7FFF_FFFF;
		s.step = 31'h7FFF_FFFF;
		s.radius_sq = '0;
		apply_settings(s);
		send_pixel(0, 0);
		send_pixel(12'd4095, 12'd4095);
		// one-LSB values: squares floor to zero, negative cross term floors away from zero
		wait_idle();
		s.c_re = 1;
		s.c_im = -1;
		s.start_re = 0;
		s.start_im = 0;
		s.step = '0;
		apply_settings(s);
		send_pixel(12'd5, 12'd5);
		// a write to the spare index changes nothing
		wait_idle();
		write_reg(CFG_UNUSED, '1);
		@(negedge clk) cfg_we <= 1'b0;
		send_pixel(12'd7, 12'd9);
	endtask

	task automatic test_random_views(input int phases, input int n);
		for (int p = 0; p < phases; p++) begin
			wait_idle();
			apply_settings(julia_view(96));
			no_idle = (p == 1);  // one stretch with both sides always ready
			send_random_pixels(n);
			no_idle = 1'b0;
		end
	endtask

	// Random values in all registers, max_iter up to 48; the orbit mostly clips and escapes early.
	task automatic test_full_range_settings(input int phases, input int n);
		cfg_t s;
		for (int p = 0; p < phases; p++) begin
			wait_idle();
			s.c_re = $urandom();
			s.c_im = $urandom();
			s.start_re = $urandom();
			s.start_im = $urandom();
			s.step = 31'($urandom());
			s.max_iter = 16'($urandom_range(0, 48));
			s.radius_sq = 31'($urandom());
			apply_settings(s);
			send_random_pixels(n);
		end
	endtask

	// Receiver holds off for a long stretch while pixels keep coming, so the output
	// register fills and in_ready drops.
	task automatic test_output_backpressure(input int n);
		wait_idle();
		apply_settings(julia_view(8));
		hold_cycles = 400;
		send_random_pixels(n / 2);
		hold_cycles = 300;
		send_random_pixels(n - n / 2);
	endtask

	task automatic test_sender_pause(input int n);
		wait_idle();
		apply_settings(julia_view(48));
		for (int k = 0; k < n; k += 15) begin
			send_random_pixels(15);
			wait_idle();
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		pixel_x = '0;
		pixel_y = '0;
		model_cfg.c_re = 0;
		model_cfg.c_im = 0;
		model_cfg.start_re = 0;
		model_cfg.start_im = 0;
		model_cfg.step = STEP_RST;
		model_cfg.max_iter = MAX_ITER_RST;
		model_cfg.radius_sq = RADIUS_RST;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		test_reset_defaults();
		test_julia_corners();
		test_iteration_limits();
		test_saturation();
		test_random_views(5, 130);
		test_full_range_settings(2, 60);
		test_output_backpressure(60);
		test_sender_pause(60);

		@(negedge clk) in_valid <= 1'b0;
		for (int n = 0; n < END_WAIT && expected_pixels.size() != 0; n++)
			@(posedge clk);
		repeat (50) @(posedge clk);  // catch any stray result
		if (expected_pixels.size() != 0)
			report_mismatch("results never returned", 0, expected_pixels.size());

		$display("Run: %0d pixels over %0d register settings (defaults, corners, clipping).",
			pixels_sent, settings_count);
		$display("Run: %0d pixels escaped, %0d reached the iteration limit.",
			escaped_seen, limit_seen);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#(LIMIT_NS);
		$display("Timeout with %0d results pending", expected_pixels.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
